// ===== src/tssd_pkg.sv =====
// Shared types and constants for the travel start/stop detector.
// No dependencies; imported by the detector modules, the checkers and the testbench.
package tssd_pkg;

	localparam int MODE_BITS = 3;
	typedef logic [MODE_BITS-1:0] mode_t;

	localparam mode_t MODE_IDLE    = 3'd0;
	localparam mode_t MODE_CONFIRM = 3'd1;
	localparam mode_t MODE_STARTED = 3'd2;
	localparam mode_t MODE_MOVING  = 3'd3;
	localparam mode_t MODE_LOST    = 3'd4;
	localparam mode_t MODE_STOPPED = 3'd5;

	localparam int SUM_BITS  = 32;
	localparam int DIST_BITS = 16;
	localparam int CFG_BITS  = 16;
	localparam int OUT_TIME_BITS = 32;

	typedef logic [SUM_BITS-1:0]  sum_t;
	typedef logic [DIST_BITS-1:0] dist_t;
	typedef logic [CFG_BITS-1:0]  cfg_t;

	// confirmation window (seconds), still limit and resume sum
	localparam cfg_t  CONFIRM_WINDOW = 16'd1;
	localparam dist_t STILL_LIMIT    = 16'd5;
	localparam sum_t  RESUME_SUM     = 32'd25;

	// register index as decoded from paddr[2]
	typedef logic reg_idx_t;
	localparam reg_idx_t REG_STOP_TIMEOUT   = 1'b0;
	localparam reg_idx_t REG_DIST_THRESHOLD = 1'b1;

	localparam cfg_t STOP_TIMEOUT_RST   = 16'd5;
	localparam cfg_t DIST_THRESHOLD_RST = 16'd100;

endpackage

// ===== src/tssd_step.sv =====
// Next-state logic of the travel state machine for one sample.
// Depends on tssd_pkg.
module tssd_step #(
	parameter int TIME_BITS = 32
) (
	input  tssd_pkg::mode_t        mode,
	input  logic [TIME_BITS-1:0]   window_start,
	input  tssd_pkg::sum_t         distance_sum,
	input  logic [TIME_BITS-1:0]   began_at,
	input  logic [TIME_BITS-1:0]   ended_at,
	input  logic [TIME_BITS-1:0]   now,
	input  tssd_pkg::dist_t        distance,
	input  tssd_pkg::cfg_t         stop_timeout,
	input  tssd_pkg::cfg_t         distance_threshold,
	output tssd_pkg::mode_t        mode_nxt,
	output logic [TIME_BITS-1:0]   window_start_nxt,
	output tssd_pkg::sum_t         distance_sum_nxt,
	output logic [TIME_BITS-1:0]   began_at_nxt,
	output logic [TIME_BITS-1:0]   ended_at_nxt
);
	import tssd_pkg::*;

	logic [TIME_BITS-1:0] elapsed;
	logic [SUM_BITS:0]    sum_wide;
	sum_t                 sum_sat;

	assign elapsed  = now - window_start;
	assign sum_wide = {1'b0, distance_sum} + (SUM_BITS+1)'(distance);
	assign sum_sat  = sum_wide[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_wide[SUM_BITS-1:0];

	always_comb begin
		mode_nxt         = mode;
		window_start_nxt = window_start;
		distance_sum_nxt = distance_sum;
		began_at_nxt     = began_at;
		ended_at_nxt     = ended_at;
		case (mode)
			MODE_CONFIRM: begin
				if (elapsed > TIME_BITS'(CONFIRM_WINDOW)) begin
					mode_nxt = (distance_sum > SUM_BITS'(distance_threshold)) ?
						MODE_STARTED : MODE_IDLE;
					distance_sum_nxt = '0;
					window_start_nxt = now;
				end else begin
					distance_sum_nxt = sum_sat;
				end
			end
			MODE_STARTED: begin
				mode_nxt     = MODE_MOVING;
				began_at_nxt = now;
				ended_at_nxt = now;
			end
			MODE_MOVING: begin
				if (distance < STILL_LIMIT) begin
					window_start_nxt = now;
					mode_nxt         = MODE_LOST;
				end
				ended_at_nxt = now;
			end
			MODE_LOST: begin
				if (elapsed > TIME_BITS'(stop_timeout)) begin
					mode_nxt = (distance_sum > RESUME_SUM) ? MODE_MOVING : MODE_STOPPED;
					distance_sum_nxt = '0;
					window_start_nxt = now;
				end else begin
					distance_sum_nxt = sum_sat;
					ended_at_nxt     = now;
				end
			end
			MODE_STOPPED: begin
				mode_nxt = MODE_IDLE;
			end
			default: begin
				// idle, and the unused codes behave as idle
				if (distance > distance_threshold) begin
					window_start_nxt = now;
					mode_nxt         = MODE_CONFIRM;
				end else begin
					mode_nxt     = MODE_IDLE;
					began_at_nxt = '0;
					ended_at_nxt = '0;
				end
			end
		endcase
	end

endmodule

// ===== src/travel_start_stop_detector_top.sv =====
// Top level of the travel start/stop detector: handshakes, APB registers, state.
// Depends on tssd_pkg and tssd_step.
//
// Takes one sample (timestamp, distance) per item and returns one result per
// item: the travel state after the update and the start and stop timestamps.
// A new sample is accepted every cycle unless the result register is stalled;
// each sample waits in the input register and its result in the result register,
// set by the single next-state step between them. The input register holds one
// sample while the result register is stalled. stop_timeout lies at byte address 0
// and distance_threshold at 4; write them only while no item is in flight.
module travel_start_stop_detector_top #(
	parameter int TIME_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	output logic                  sample_ready,
	input  logic [31:0]           now_time,
	input  tssd_pkg::dist_t       distance,
	output logic                  result_valid,
	input  logic                  result_ready,
	output tssd_pkg::mode_t       travel_state,
	output logic [31:0]           start_time,
	output logic [31:0]           stop_time,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	import tssd_pkg::*;

	cfg_t stop_timeout_q;
	cfg_t distance_threshold_q;
	reg_idx_t reg_idx;

	logic                 valid_s1;
	logic [TIME_BITS-1:0] now_s1;
	dist_t                distance_s1;
	logic                 advance;

	mode_t                mode_q;
	logic [TIME_BITS-1:0] window_start_q;
	sum_t                 distance_sum_q;
	logic [TIME_BITS-1:0] began_at_q;
	logic [TIME_BITS-1:0] ended_at_q;

	mode_t                mode_nxt;
	logic [TIME_BITS-1:0] window_start_nxt;
	sum_t                 distance_sum_nxt;
	logic [TIME_BITS-1:0] began_at_nxt;
	logic [TIME_BITS-1:0] ended_at_nxt;

	logic                 result_valid_q;
	mode_t                travel_state_q;
	logic [31:0]          start_time_q;
	logic [31:0]          stop_time_q;

	// configuration port
	assign pready  = 1'b1;
	assign reg_idx = paddr[2];

	always_comb begin
		case (reg_idx)
			REG_STOP_TIMEOUT:   prdata = 32'(stop_timeout_q);
			REG_DIST_THRESHOLD: prdata = 32'(distance_threshold_q);
			default:            prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_timeout_q       <= STOP_TIMEOUT_RST;
			distance_threshold_q <= DIST_THRESHOLD_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_STOP_TIMEOUT:   stop_timeout_q       <= pwdata[CFG_BITS-1:0];
				REG_DIST_THRESHOLD: distance_threshold_q <= pwdata[CFG_BITS-1:0];
				default: ;
			endcase
		end
	end

	// input register
	assign advance      = valid_s1 && (!result_valid_q || result_ready);
	assign sample_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			now_s1      <= TIME_BITS'(now_time);
			distance_s1 <= distance;
		end
	end

	tssd_step #(
		.TIME_BITS(TIME_BITS)
	) u_step (
		.mode               (mode_q),
		.window_start       (window_start_q),
		.distance_sum       (distance_sum_q),
		.began_at           (began_at_q),
		.ended_at           (ended_at_q),
		.now                (now_s1),
		.distance           (distance_s1),
		.stop_timeout       (stop_timeout_q),
		.distance_threshold (distance_threshold_q),
		.mode_nxt           (mode_nxt),
		.window_start_nxt   (window_start_nxt),
		.distance_sum_nxt   (distance_sum_nxt),
		.began_at_nxt       (began_at_nxt),
		.ended_at_nxt       (ended_at_nxt)
	);

	// machine state moves on when the item leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_IDLE;
			window_start_q <= '0;
			distance_sum_q <= '0;
			began_at_q     <= '0;
			ended_at_q     <= '0;
		end else if (advance) begin
			mode_q         <= mode_nxt;
			window_start_q <= window_start_nxt;
			distance_sum_q <= distance_sum_nxt;
			began_at_q     <= began_at_nxt;
			ended_at_q     <= ended_at_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			travel_state_q <= mode_nxt;
			start_time_q   <= OUT_TIME_BITS'(began_at_nxt);
			stop_time_q    <= OUT_TIME_BITS'(ended_at_nxt);
		end
	end

	assign result_valid = result_valid_q;
	assign travel_state = travel_state_q;
	assign start_time   = start_time_q;
	assign stop_time    = stop_time_q;

endmodule

// ===== src/tssd_checker.sv =====
// Port-level checks on the travel start/stop detector, bound to the top level.
// Depends on tssd_pkg and travel_start_stop_detector_top.
module tssd_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  result_valid,
	input logic                  result_ready,
	input tssd_pkg::mode_t       travel_state,
	input logic [31:0]           start_time,
	input logic [31:0]           stop_time
);
	import tssd_pkg::*;

	logic  seen_q;
	mode_t last_q;
	logic  deliver;

	assign deliver = result_valid && result_ready;

	// last delivered state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
			last_q <= MODE_IDLE;
		end else if (deliver) begin
			seen_q <= 1'b1;
			last_q <= travel_state;
		end
	end

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(travel_state) && $stable(start_time) && $stable(stop_time))
		else $error("result changed while stalled");

	a_started_then_moving: assert property (@(posedge clk) disable iff (!arst_n)
		deliver && seen_q && last_q == MODE_STARTED |->
			travel_state == MODE_MOVING && start_time == stop_time)
		else $error("started item not followed by moving with equal times");

	a_stopped_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		deliver && seen_q && last_q == MODE_STOPPED |-> travel_state == MODE_IDLE)
		else $error("stopped item not followed by idle");

	a_moving_next: assert property (@(posedge clk) disable iff (!arst_n)
		deliver && seen_q && last_q == MODE_MOVING |->
			travel_state == MODE_MOVING || travel_state == MODE_LOST)
		else $error("moving item followed by an impossible state");

endmodule

bind travel_start_stop_detector_top tssd_checker u_tssd_checker (.*);

// ===== verif/travel_result_checker.sv =====
// Checker for the travel start/stop detector: predicts one report per sample and
// compares it with the result channel. Tracks register writes on the APB port.
// Depends on tssd_pkg.
module travel_result_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            sample_valid,
	input  logic            sample_ready,
	input  logic [31:0]     now_time,
	input  tssd_pkg::dist_t distance,
	input  logic            result_valid,
	input  logic            result_ready,
	input  tssd_pkg::mode_t travel_state,
	input  logic [31:0]     start_time,
	input  logic [31:0]     stop_time,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic            pready,
	input  logic [2:0]      paddr,
	input  logic [31:0]     pwdata,
	output int              mismatches,
	output int              reports_pending,
	output int              reports_checked,
	output logic [5:0]      states_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import tssd_pkg::*;

	typedef struct packed {
		mode_t       state;
		logic [31:0] started;
		logic [31:0] stopped;
	} travel_report_t;

	// predicted detector state and register copies
	mode_t          fsm_mode;
	logic [31:0]    window_t0;
	sum_t           moved_sum;
	logic [31:0]    trip_begin;
	logic [31:0]    trip_end;
	cfg_t           stop_after;
	cfg_t           move_threshold;
	travel_report_t expected_reports[$];
	int             fail_tally;
	int             checked_tally;

	function automatic sum_t add_saturated(input sum_t acc, input dist_t moved);
		logic [SUM_BITS:0] total;
		total = {1'b0, acc} + (SUM_BITS+1)'(moved);
		return total[SUM_BITS] ? {SUM_BITS{1'b1}} : total[SUM_BITS-1:0];
	endfunction

	function automatic travel_report_t step_travel_fsm(input logic [31:0] now, input dist_t moved);
		logic [31:0]    elapsed;
		travel_report_t rep;
		elapsed = now - window_t0;
		case (fsm_mode)
		MODE_CONFIRM: begin
			if (elapsed > CONFIRM_WINDOW) begin
				fsm_mode = (moved_sum > move_threshold) ? MODE_STARTED : MODE_IDLE;
				moved_sum = '0;
				window_t0 = now;
			end else begin
				moved_sum = add_saturated(moved_sum, moved);
			end
		end
		MODE_STARTED: begin
			fsm_mode = MODE_MOVING;
			trip_begin = now;
			trip_end = now;
		end
		MODE_MOVING: begin
			if (moved < STILL_LIMIT) begin
				window_t0 = now;
				fsm_mode = MODE_LOST;
			end
			trip_end = now;
		end
		MODE_LOST: begin
			if (elapsed > stop_after) begin
				fsm_mode = (moved_sum > RESUME_SUM) ? MODE_MOVING : MODE_STOPPED;
				moved_sum = '0;
				window_t0 = now;
			end else begin
				moved_sum = add_saturated(moved_sum, moved);
				trip_end = now;
			end
		end
		MODE_STOPPED: begin
			fsm_mode = MODE_IDLE;
		end
		default: begin
			if (moved > move_threshold) begin
				window_t0 = now;
				fsm_mode = MODE_CONFIRM;
			end else begin
				fsm_mode = MODE_IDLE;
				trip_begin = '0;
				trip_end = '0;
			end
		end
		endcase
		rep.state = fsm_mode;
		rep.started = trip_begin;
		rep.stopped = trip_end;
		return rep;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		travel_report_t want;
		if (!arst_n) begin
			fsm_mode = MODE_IDLE;
			window_t0 = '0;
			moved_sum = '0;
			trip_begin = '0;
			trip_end = '0;
			stop_after = STOP_TIMEOUT_RST;
			move_threshold = DIST_THRESHOLD_RST;
			expected_reports.delete();
			fail_tally = 0;
			checked_tally = 0;
			mismatches <= 0;
			reports_pending <= 0;
			reports_checked <= 0;
			states_seen <= '0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[2]))
				REG_STOP_TIMEOUT:   stop_after = pwdata[CFG_BITS-1:0];
				REG_DIST_THRESHOLD: move_threshold = pwdata[CFG_BITS-1:0];
				default: ;
				endcase
			end
			// compare before pushing, so a stray result never meets this cycle's item
			if (result_valid && result_ready) begin
				if (travel_state <= MODE_STOPPED)
					states_seen <= states_seen | (6'b1 << travel_state);
				if (expected_reports.size() == 0) begin
					$error("result with no sample outstanding: state %0d start %0d stop %0d",
						travel_state, start_time, stop_time);
					fail_tally++;
				end else begin
					want = expected_reports.pop_front();
					checked_tally++;
					if (travel_state !== want.state) begin
						$error("travel_state: expected %0d, got %0d", want.state, travel_state);
						fail_tally++;
					end
					if (start_time !== want.started) begin
						$error("start_time: expected %0d, got %0d", want.started, start_time);
						fail_tally++;
					end
					if (stop_time !== want.stopped) begin
						$error("stop_time: expected %0d, got %0d", want.stopped, stop_time);
						fail_tally++;
					end
				end
			end
			if (sample_valid && sample_ready)
				expected_reports.push_back(step_travel_fsm(now_time, distance));
			mismatches <= fail_tally;
			reports_pending <= expected_reports.size();
			reports_checked <= checked_tally;
		end
	end

endmodule

// ===== verif/tb_travel_start_stop_detector_top.sv =====
// Testbench top for the travel start/stop detector: clock, reset, sample and
// register stimulus, receiver pacing and the verdict.
// Depends on tssd_pkg, travel_start_stop_detector_top and travel_result_checker.
module tb_travel_start_stop_detector_top;
	timeunit 1ns;
	timeprecision 1ps;
	import tssd_pkg::*;

	localparam int QUIET_LIMIT = 1000;
	localparam int HOLD_CYCLES = 60;

	typedef enum logic [1:0] {
		PACE_FULL,
		PACE_SEND_GAPS,
		PACE_RECV_STALLS,
		PACE_BOTH
	} pace_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        sample_valid = 1'b0;
	logic        sample_ready;
	logic [31:0] now_time = '0;
	dist_t       distance = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	mode_t       travel_state;
	logic [31:0] start_time;
	logic [31:0] stop_time;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int          mismatches;
	int          reports_pending;
	int          reports_checked;
	logic [5:0]  states_seen;

	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          hold_seq = 0;
	int          hold_seen = 0;
	int          hold_left = 0;
	int          quiet_cycles = 0;
	int          samples_sent = 0;
	int          settings_used = 0;
	cfg_t        cur_timeout = STOP_TIMEOUT_RST;
	cfg_t        cur_threshold = DIST_THRESHOLD_RST;
	logic [31:0] clock_s = '0;

	travel_start_stop_detector_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.now_time     (now_time),
		.distance     (distance),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.travel_state (travel_state),
		.start_time   (start_time),
		.stop_time    (stop_time),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	travel_result_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.sample_valid    (sample_valid),
		.sample_ready    (sample_ready),
		.now_time        (now_time),
		.distance        (distance),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.travel_state    (travel_state),
		.start_time      (start_time),
		.stop_time       (stop_time),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.pready          (pready),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.mismatches      (mismatches),
		.reports_pending (reports_pending),
		.reports_checked (reports_checked),
		.states_seen     (states_seen)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// receiver: random stalls, plus a long hold-off each time hold_seq moves on
	always @(posedge clk) begin
		if (hold_seen != hold_seq) begin
			hold_seen <= hold_seq;
			hold_left <= HOLD_CYCLES;
			result_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// the limit is several times the longest quiet stretch of a correct run
	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_valid && sample_ready) || (result_valid && result_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: nothing accepted for %0d cycles", QUIET_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	task automatic offer_sample(input logic [31:0] t, input dist_t moved);
		int gap;
		gap = 0;
		while (gap < 24 && $urandom_range(0, 99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		now_time <= t;
		distance <= moved;
		do
			@(posedge clk);
		while (!sample_ready);
		samples_sent++;
	endtask

	// sender stops and waits for every outstanding report, then the pipeline latency
	task automatic settle();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (reports_pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input cfg_t value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= {16'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic configure(input cfg_t timeout, input cfg_t threshold, input pace_t pace);
		settle();
		write_reg(REG_STOP_TIMEOUT, timeout);
		write_reg(REG_DIST_THRESHOLD, threshold);
		cur_timeout = timeout;
		cur_threshold = threshold;
		settings_used++;
		case (pace)
		PACE_FULL:        begin send_idle_pct = 0;  recv_stall_pct = 0;  end
		PACE_SEND_GAPS:   begin send_idle_pct = 70; recv_stall_pct = 0;  end
		PACE_RECV_STALLS: begin send_idle_pct = 0;  recv_stall_pct = 70; end
		default:          begin send_idle_pct = 31; recv_stall_pct = 31; end
		endcase
	endtask

	// one attempted journey: trigger, confirm, start, move, lose movement
	// (sometimes resuming), stop and fall back to idle
	task automatic travel_trip();
		logic [31:0] ws;
		int          n;
		bit          faint;
		bit          resume;
		bit          again;
		if ($urandom_range(0, 19) == 0)
			clock_s = 32'hFFFF_FFFF - $urandom_range(0, 6);
		repeat ($urandom_range(0, 2)) begin
			clock_s += $urandom_range(0, 2);
			offer_sample(clock_s, dist_t'($urandom_range(0, cur_threshold)));
		end
		clock_s += $urandom_range(1, 3);
		ws = clock_s;
		if (cur_threshold == '1)
			offer_sample(clock_s, '1);
		else
			offer_sample(clock_s, dist_t'($urandom_range(cur_threshold + 1, 65535)));
		n = $urandom_range(2, 4);
		faint = ($urandom_range(0, 9) == 0);
		repeat (n) begin
			clock_s = ws + $urandom_range(0, 1);
			if (faint)
				offer_sample(clock_s, dist_t'($urandom_range(0, cur_threshold / 4)));
			else
				offer_sample(clock_s,
					dist_t'($urandom_range(cur_threshold / 2 + 1, 65535)));
		end
		clock_s = ws + 2 + $urandom_range(0, 2);
		offer_sample(clock_s, dist_t'($urandom));
		clock_s += $urandom_range(0, 1);
		offer_sample(clock_s, dist_t'($urandom));
		again = 1'b1;
		resume = ($urandom_range(0, 2) == 0);
		while (again) begin
			repeat ($urandom_range(1, 6)) begin
				clock_s += $urandom_range(0, 2);
				offer_sample(clock_s, dist_t'($urandom_range(STILL_LIMIT, 65535)));
			end
			clock_s += $urandom_range(0, 2);
			ws = clock_s;
			offer_sample(clock_s, dist_t'($urandom_range(0, STILL_LIMIT - 1)));
			n = resume ? $urandom_range(1, 3) : $urandom_range(0, 3);
			repeat (n) begin
				clock_s = ws + $urandom_range(0, cur_timeout);
				if (resume)
					offer_sample(clock_s, dist_t'($urandom_range(26, 65535)));
				else
					offer_sample(clock_s, dist_t'($urandom_range(0, 6)));
			end
			clock_s = ws + cur_timeout + 1 + $urandom_range(0, 3);
			offer_sample(clock_s, dist_t'($urandom));
			again = resume;
			resume = 1'b0;
		end
		clock_s += $urandom_range(0, 2);
		offer_sample(clock_s, dist_t'($urandom));
		clock_s += 1;
		offer_sample(clock_s, dist_t'($urandom_range(0, cur_threshold)));
	endtask

	// random timestamps, time running backwards, random distances
	task automatic noise_burst();
		repeat ($urandom_range(1, 4)) begin
			case ($urandom_range(0, 2))
			0:       clock_s = $urandom;
			1:       clock_s -= $urandom_range(1, 1000);
			default: clock_s += $urandom_range(0, 5);
			endcase
			offer_sample(clock_s, dist_t'($urandom));
		end
	endtask

	task automatic random_phase(input int count);
		int goal;
		goal = samples_sent + count;
		while (samples_sent < goal) begin
			if ($urandom_range(0, 3) != 0)
				travel_trip();
			else
				noise_burst();
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset register values, threshold 100, timeout 5
		offer_sample(32'd100, 16'd0);
		offer_sample(32'd100, 16'd100);
		offer_sample(32'd101, 16'd101);
		offer_sample(32'd101, 16'hFFFF);
		offer_sample(32'd102, 16'd0);
		offer_sample(32'd103, 16'd7);
		offer_sample(32'd104, 16'd0);
		offer_sample(32'd105, 16'd5);
		offer_sample(32'd106, 16'd4);
		offer_sample(32'd111, 16'd30);
		offer_sample(32'd112, 16'd0);
		offer_sample(32'd113, 16'd0);
		offer_sample(32'd118, 16'd25);
		offer_sample(32'd119, 16'd0);
		offer_sample(32'd120, 16'hFFFF);
		offer_sample(32'd121, 16'd0);
		// timestamp going backwards reads as a long elapsed time
		offer_sample(32'd200, 16'd101);
		offer_sample(32'd150, 16'd50);
		// timestamps wrapping through zero
		offer_sample(32'hFFFF_FFFF, 16'd500);
		offer_sample(32'd0, 16'd200);
		offer_sample(32'd1, 16'd0);
		offer_sample(32'd2, 16'd0);
		offer_sample(32'd2, 16'd4);
		offer_sample(32'd3, 16'd0);
		offer_sample(32'd8, 16'd0);
		offer_sample(32'd9, 16'hFFFF);
		clock_s = 32'd1000;

		configure(16'd5, 16'd100, PACE_FULL);
		random_phase(200);
		configure(16'd0, 16'd0, PACE_SEND_GAPS);
		random_phase(150);
		configure(16'hFFFF, 16'd40000, PACE_RECV_STALLS);
		random_phase(150);
		configure(16'd3, 16'hFFFF, PACE_BOTH);
		random_phase(80);
		configure(16'd7, 16'd300, PACE_BOTH);
		random_phase(100);
		// receiver holds off while samples keep coming: the block fills and stalls
		hold_seq <= hold_seq + 1;
		random_phase(50);
		settle();
		random_phase(100);
		configure(16'd2, 16'd20, PACE_FULL);
		random_phase(150);
		settle();

		$display("Run covered %0d samples over %0d register settings; %0d reports checked.",
			samples_sent, settings_used, reports_checked);
		$display("Travel states reported (one bit per state, idle lowest): %b", states_seen);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
